// ----- rtl/rthsv_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rthsv_pkg: shared types and constants of the RGB to HSV pixel converter
// Channel widths, divider geometry, hue offsets and the side-band record
// that travels alongside the dividers.
// ----------------------------------------------------------------------------
package rthsv_pkg;

   // Pixel channel width
   localparam int CH_W  = 8;
   // Divider geometry: quotient bits, numerator bits (= divisor + quotient)
   localparam int QUO_W = 8;
   localparam int NUM_W = CH_W + QUO_W;
   // Hue numerator width before extension to the divider width
   localparam int HNUM_W = 14;
   // Hue sum width: signed, holds -60..300 and 0..359 after wrap
   localparam int HSUM_W = 10;

   // Scale factors and hue offsets in degrees
   localparam logic [CH_W-1:0]   SAT_SCALE      = 8'd255;
   localparam logic [5:0]        HUE_SCALE      = 6'd60;
   localparam logic [CH_W-1:0]   HUE_BASE_RED   = 8'd0;
   localparam logic [CH_W-1:0]   HUE_BASE_GREEN = 8'd120;
   localparam logic [CH_W-1:0]   HUE_BASE_BLUE  = 8'd240;
   localparam logic [HSUM_W-1:0] HUE_WRAP       = 10'd360;

   // Channel that holds the maximum (first of red, green, blue on ties)
   typedef enum logic [2:0] {
      SEC_RED   = 3'b001,
      SEC_GREEN = 3'b010,
      SEC_BLUE  = 3'b100
   } sector_type;

   // Per-pixel control and data that bypasses the dividers
   typedef struct packed {
      logic             valid;
      logic [CH_W-1:0]  brightness;
      sector_type       sector;
      logic             negative;
      logic             gray;
      logic             black;
   } side_type;

endpackage
`default_nettype wire

// ----- rtl/rthsv_prep.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rthsv_prep: front end of the converter
// Stage A finds maximum, minimum, sector and signed channel difference.
// Stage B forms chroma and the scaled numerators for both dividers.
// ----------------------------------------------------------------------------
module rthsv_prep (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   input  wire  [rthsv_pkg::CH_W-1:0]   red,
   input  wire  [rthsv_pkg::CH_W-1:0]   green,
   input  wire  [rthsv_pkg::CH_W-1:0]   blue,
   output rthsv_pkg::side_type          side_o,
   output logic [rthsv_pkg::NUM_W-1:0]  sat_num_o,
   output logic [rthsv_pkg::CH_W-1:0]   sat_den_o,
   output logic [rthsv_pkg::NUM_W-1:0]  hue_num_o,
   output logic [rthsv_pkg::CH_W-1:0]   hue_den_o
);
   import rthsv_pkg::*;

   // Stage A registers
   logic                   valid_a_ff;
   logic [CH_W-1:0]        max_a_ff, max_a_in;
   logic [CH_W-1:0]        min_a_ff, min_a_in;
   sector_type             sector_a_ff, sector_a_in;
   logic signed [CH_W:0]   diff_a_ff, diff_a_in;

   // Stage B registers
   side_type               side_b_ff, side_b_in;
   logic [NUM_W-1:0]       sat_num_b_ff, sat_num_b_in;
   logic [CH_W-1:0]        sat_den_b_ff;
   logic [NUM_W-1:0]       hue_num_b_ff, hue_num_b_in;
   logic [CH_W-1:0]        hue_den_b_ff, chroma;
   logic [CH_W-1:0]        diff_abs;

   // Pick the maximum channel, red first, then green
   always_comb begin
      if (red >= green && red >= blue) begin
         sector_a_in = SEC_RED;
         max_a_in    = red;
         diff_a_in   = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (green >= blue) begin
         sector_a_in = SEC_GREEN;
         max_a_in    = green;
         diff_a_in   = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         sector_a_in = SEC_BLUE;
         max_a_in    = blue;
         diff_a_in   = $signed({1'b0, red}) - $signed({1'b0, green});
      end
      min_a_in = red;
      if (green < min_a_in) min_a_in = green;
      if (blue < min_a_in)  min_a_in = blue;
   end

   // Advance stage A
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else begin
         valid_a_ff <= start;
      end
      max_a_ff    <= max_a_in;
      min_a_ff    <= min_a_in;
      sector_a_ff <= sector_a_in;
      diff_a_ff   <= diff_a_in;
   end

   // Form chroma, magnitude of the difference and both numerators
   always_comb begin
      chroma   = max_a_ff - min_a_ff;
      diff_abs = diff_a_ff[CH_W] ? CH_W'(-diff_a_ff) : diff_a_ff[CH_W-1:0];
      sat_num_b_in = NUM_W'(chroma) * NUM_W'(SAT_SCALE);
      hue_num_b_in = NUM_W'(HNUM_W'(diff_abs) * HNUM_W'(HUE_SCALE));
      side_b_in.valid      = valid_a_ff;
      side_b_in.brightness = max_a_ff;
      side_b_in.sector     = sector_a_ff;
      side_b_in.negative   = diff_a_ff[CH_W];
      side_b_in.gray       = (chroma == '0);
      side_b_in.black      = (max_a_ff == '0);
   end

   // Advance stage B
   always_ff @(posedge clock) begin
      if (reset) begin
         side_b_ff.valid <= 1'b0;
      end else begin
         side_b_ff <= side_b_in;
      end
      sat_num_b_ff <= sat_num_b_in;
      sat_den_b_ff <= max_a_ff;
      hue_num_b_ff <= hue_num_b_in;
      hue_den_b_ff <= chroma;
   end

   assign side_o    = side_b_ff;
   assign sat_num_o = sat_num_b_ff;
   assign sat_den_o = sat_den_b_ff;
   assign hue_num_o = hue_num_b_ff;
   assign hue_den_o = hue_den_b_ff;

endmodule
`default_nettype wire

// ----- rtl/rthsv_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rthsv_div: pipelined restoring divider
// One quotient bit per register stage, most significant first. The caller
// keeps the quotient below 2**QUO_W and masks a zero divisor.
// ----------------------------------------------------------------------------
module rthsv_div (
   input  wire                          clock,
   input  wire  [rthsv_pkg::NUM_W-1:0]  num_i,
   input  wire  [rthsv_pkg::CH_W-1:0]   den_i,
   output logic [rthsv_pkg::QUO_W-1:0]  quo_o
);
   import rthsv_pkg::*;

   // Stage registers: partial remainder, divisor and quotient so far
   logic [NUM_W-1:0]  rem_ff [QUO_W];
   logic [CH_W-1:0]   den_ff [QUO_W];
   logic [QUO_W-1:0]  quo_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      localparam int Shift = QUO_W - 1 - k;
      logic [NUM_W-1:0]  rem_cur, rem_in;
      logic [CH_W-1:0]   den_cur;
      logic [QUO_W-1:0]  quo_cur, quo_in;
      logic [NUM_W:0]    trial;

      // Take the stage input from the ports or from the previous stage
      if (k == 0) begin : g_first
         assign rem_cur = num_i;
         assign den_cur = den_i;
         assign quo_cur = '0;
      end else begin : g_next
         assign rem_cur = rem_ff[k-1];
         assign den_cur = den_ff[k-1];
         assign quo_cur = quo_ff[k-1];
      end

      // Try to subtract the shifted divisor, keep the result if it fits
      always_comb begin
         trial  = {1'b0, rem_cur} - {1'b0, (NUM_W'(den_cur) << Shift)};
         rem_in = trial[NUM_W] ? rem_cur : trial[NUM_W-1:0];
         quo_in = {quo_cur[QUO_W-2:0], ~trial[NUM_W]};
      end

      // Advance one stage
      always_ff @(posedge clock) begin
         rem_ff[k] <= rem_in;
         den_ff[k] <= den_cur;
         quo_ff[k] <= quo_in;
      end
   end

   assign quo_o = quo_ff[QUO_W-1];

endmodule
`default_nettype wire

// ----- rtl/rthsv_post.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rthsv_post: back end of the converter
// Adds the sector offset to the signed hue quotient, wraps and halves it,
// masks gray and black pixels, and registers the result.
// ----------------------------------------------------------------------------
module rthsv_post (
   input  wire                          clock,
   input  wire                          reset,
   input  rthsv_pkg::side_type          side_i,
   input  wire  [rthsv_pkg::QUO_W-1:0]  sat_quo_i,
   input  wire  [rthsv_pkg::QUO_W-1:0]  hue_quo_i,
   output logic                         rsp_valid,
   output logic [rthsv_pkg::CH_W-1:0]   rsp_hue,
   output logic [rthsv_pkg::CH_W-1:0]   rsp_saturation,
   output logic [rthsv_pkg::CH_W-1:0]   rsp_brightness
);
   import rthsv_pkg::*;

   logic                      valid_ff;
   logic [CH_W-1:0]           hue_ff, hue_in;
   logic [CH_W-1:0]           sat_ff, sat_in;
   logic [CH_W-1:0]           bright_ff;
   logic [CH_W-1:0]           base;
   logic signed [HSUM_W-1:0]  hue_sum;
   logic [HSUM_W-1:0]         hue_deg;

   // Build hue in degrees, wrap negatives, halve
   always_comb begin
      case (side_i.sector)
         SEC_GREEN: base = HUE_BASE_GREEN;
         SEC_BLUE:  base = HUE_BASE_BLUE;
         default:   base = HUE_BASE_RED;
      endcase
      if (side_i.negative) begin
         hue_sum = $signed({2'b00, base}) - $signed({2'b00, hue_quo_i});
      end else begin
         hue_sum = $signed({2'b00, base}) + $signed({2'b00, hue_quo_i});
      end
      if (hue_sum[HSUM_W-1]) begin
         hue_deg = hue_sum + HUE_WRAP;
      end else begin
         hue_deg = hue_sum;
      end
      hue_in = side_i.gray  ? '0 : hue_deg[CH_W:1];
      sat_in = side_i.black ? '0 : sat_quo_i;
   end

   // Register the result
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= side_i.valid;
      end
      hue_ff    <= hue_in;
      sat_ff    <= sat_in;
      bright_ff <= side_i.brightness;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_hue        = hue_ff;
   assign rsp_saturation = sat_ff;
   assign rsp_brightness = bright_ff;

endmodule
`default_nettype wire

// ----- rtl/rgb_to_hsv_pixel.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel: 8-bit RGB to 8-bit HSV pixel converter
// A new pixel is taken in every clock cycle; busy is always low. The result
// of a pixel is on rsp_valid for one cycle. It passes through 11 register
// stages: two of front end (the first one loads at the edge that takes the
// pixel), eight stages of the two restoring dividers that run side by side
// (one quotient bit per stage), and one output stage. The receiver has no
// way to hold results off and needs none.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire  [rthsv_pkg::CH_W-1:0]   req_red,
   input  wire  [rthsv_pkg::CH_W-1:0]   req_green,
   input  wire  [rthsv_pkg::CH_W-1:0]   req_blue,
   output logic                         rsp_valid,
   output logic [rthsv_pkg::CH_W-1:0]   rsp_hue,
   output logic [rthsv_pkg::CH_W-1:0]   rsp_saturation,
   output logic [rthsv_pkg::CH_W-1:0]   rsp_brightness
);
   import rthsv_pkg::*;

   side_type          prep_side;
   logic [NUM_W-1:0]  sat_num, hue_num;
   logic [CH_W-1:0]   sat_den, hue_den;
   logic [QUO_W-1:0]  sat_quo, hue_quo;
   side_type          side_ff [QUO_W];

   // The pipeline never stalls
   assign busy = 1'b0;

   rthsv_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .red       (req_red),
      .green     (req_green),
      .blue      (req_blue),
      .side_o    (prep_side),
      .sat_num_o (sat_num),
      .sat_den_o (sat_den),
      .hue_num_o (hue_num),
      .hue_den_o (hue_den)
   );

   rthsv_div u_sat_div (
      .clock (clock),
      .num_i (sat_num),
      .den_i (sat_den),
      .quo_o (sat_quo)
   );

   rthsv_div u_hue_div (
      .clock (clock),
      .num_i (hue_num),
      .den_i (hue_den),
      .quo_o (hue_quo)
   );

   // Delay side-band data to match the divider latency
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < QUO_W; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else begin
         side_ff[0] <= prep_side;
         for (int k = 1; k < QUO_W; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   rthsv_post u_post (
      .clock          (clock),
      .reset          (reset),
      .side_i         (side_ff[QUO_W-1]),
      .sat_quo_i      (sat_quo),
      .hue_quo_i      (hue_quo),
      .rsp_valid      (rsp_valid),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

endmodule
`default_nettype wire

// ----- tb/rgb_to_hsv_pixel_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel_tb: self-checking bench for the RGB to HSV pixel converter
// Sends a directed set of corner pixels (black, white, grays, primaries, ties
// for the maximum, negative hue) and then about 1400 random pixels in bursts
// with random gaps. Every transfer gets its HSV result predicted in the bench
// and every strobed result is checked field by field in order.
// ----------------------------------------------------------------------------
module rgb_to_hsv_pixel_tb;
   import rthsv_pkg::*;

   localparam int RANDOM_PIXELS = 1400;
   localparam int DRAIN_EVERY   = 350;
   localparam int TAIL_CYCLES   = 20;

   typedef struct {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
      bit              drain;
   } pixel_type;

   typedef struct {
      logic [CH_W-1:0] hue;
      logic [CH_W-1:0] saturation;
      logic [CH_W-1:0] brightness;
   } hsv_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            start = 1'b0;
   logic            busy;
   logic [CH_W-1:0] req_red   = '0;
   logic [CH_W-1:0] req_green = '0;
   logic [CH_W-1:0] req_blue  = '0;
   logic            rsp_valid;
   logic [CH_W-1:0] rsp_hue;
   logic [CH_W-1:0] rsp_saturation;
   logic [CH_W-1:0] rsp_brightness;

   pixel_type pixels_to_send[$];
   hsv_type   hsv_expected[$];
   int     pixels_taken  = 0;
   int     results_seen  = 0;
   int     error_count   = 0;
   int     burst_left    = 0;
   int     gap_left      = 0;
   int     drain_count   = 0;
   int     directed_count = 0;

   rgb_to_hsv_pixel dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_red        (req_red),
      .req_green      (req_green),
      .req_blue       (req_blue),
      .rsp_valid      (rsp_valid),
      .rsp_hue        (rsp_hue),
      .rsp_saturation (rsp_saturation),
      .rsp_brightness (rsp_brightness)
   );

   // Clock generation
   initial begin
      forever #5 clock = ~clock;
   end

   // Hold reset at the start, then release it for good
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Compute the HSV triple of one pixel
   function automatic hsv_type hsv_of(input logic [CH_W-1:0] r, g, b);
      hsv_type res;
      int   ri;
      int   gi;
      int   bi;
      int   hi;
      int   lo;
      int   chroma;
      int   deg;
      ri = int'(r);
      gi = int'(g);
      bi = int'(b);
      hi = ri;
      if (gi > hi) hi = gi;
      if (bi > hi) hi = bi;
      lo = ri;
      if (gi < lo) lo = gi;
      if (bi < lo) lo = bi;
      chroma = hi - lo;
      deg = 0;
      // First channel equal to the maximum picks the hue sector
      if (chroma != 0) begin
         if (hi == ri) begin
            deg = (60 * (gi - bi)) / chroma;
         end else if (hi == gi) begin
            deg = 120 + (60 * (bi - ri)) / chroma;
         end else begin
            deg = 240 + (60 * (ri - gi)) / chroma;
         end
         if (deg < 0) deg += 360;
         deg = deg / 2;
      end
      res.hue        = deg[CH_W-1:0];
      res.saturation = (hi != 0) ? CH_W'((255 * chroma) / hi) : '0;
      res.brightness = hi[CH_W-1:0];
      return res;
   endfunction

   // Print one mismatch line and count it
   task automatic report_mismatch(input string what, input int got, input int want);
      if (error_count < 40)
         $display("%0t: %s: got %0d, expected %0d (result %0d)",
                  $realtime, what, got, want, results_seen);
      error_count++;
   endtask

   // Queue one pixel for the driver
   task automatic add_pixel(input int r, input int g, input int b, input bit drain);
      pixel_type p;
      p.red   = r[CH_W-1:0];
      p.green = g[CH_W-1:0];
      p.blue  = b[CH_W-1:0];
      p.drain = drain;
      pixels_to_send.push_back(p);
   endtask

   // Driver: present pixels in bursts, hold each one until it is taken
   always @(posedge clock) begin
      pixel_type pix;
      if (reset) begin
         start      <= 1'b0;
         burst_left <= 0;
         gap_left   <= 0;
      end else begin
         if (start && !busy)
            pixels_taken <= pixels_taken + 1;
         if (start && busy) begin
            // hold the current pixel
         end else if (gap_left != 0) begin
            start    <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pixels_to_send.size() != 0 && pixels_to_send[0].drain &&
                      (start || results_seen != pixels_taken)) begin
            // pause until every pending result is back
            start <= 1'b0;
         end else if (pixels_to_send.size() != 0) begin
            pix = pixels_to_send.pop_front();
            if (pix.drain)
               drain_count <= drain_count + 1;
            req_red   <= pix.red;
            req_green <= pix.green;
            req_blue  <= pix.blue;
            start     <= 1'b1;
            hsv_expected.push_back(hsv_of(pix.red, pix.green, pix.blue));
            // close the burst with a gap, or keep streaming
            if (burst_left == 0) begin
               burst_left <= $urandom_range(1, 40);
               gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: check every strobed result against the oldest prediction
   always @(posedge clock) begin
      hsv_type want;
      int   in_flight;
      if (!reset && rsp_valid) begin
         in_flight = pixels_taken + ((start && !busy) ? 1 : 0) - results_seen;
         if (in_flight <= 0) begin
            report_mismatch("result with no pixel waiting", int'(rsp_hue), 0);
         end else begin
            want = hsv_expected.pop_front();
            if (rsp_hue !== want.hue)
               report_mismatch("hue", int'(rsp_hue), int'(want.hue));
            if (rsp_saturation !== want.saturation)
               report_mismatch("saturation", int'(rsp_saturation),
                               int'(want.saturation));
            if (rsp_brightness !== want.brightness)
               report_mismatch("brightness", int'(rsp_brightness),
                               int'(want.brightness));
            results_seen <= results_seen + 1;
         end
      end
   end

   // Stimulus and end of run
   initial begin
      int r;
      int g;
      int b;
      int v;
      int pick;
      int waited;

      // Directed corners: black, white, grays, primaries, ties, negative hue
      add_pixel(0, 0, 0, 0);
      add_pixel(255, 255, 255, 0);
      add_pixel(128, 128, 128, 0);
      add_pixel(1, 1, 1, 0);
      add_pixel(255, 0, 0, 0);
      add_pixel(0, 255, 0, 0);
      add_pixel(0, 0, 255, 0);
      add_pixel(255, 255, 0, 0);
      add_pixel(0, 255, 255, 0);
      add_pixel(255, 0, 255, 0);
      add_pixel(255, 0, 128, 0);
      add_pixel(255, 0, 1, 0);
      add_pixel(255, 1, 0, 0);
      add_pixel(1, 0, 0, 0);
      add_pixel(0, 0, 1, 0);
      add_pixel(1, 0, 1, 0);
      add_pixel(0, 1, 1, 0);
      add_pixel(255, 254, 254, 0);
      add_pixel(170, 85, 170, 0);
      add_pixel(85, 170, 255, 0);
      add_pixel(128, 64, 200, 0);
      add_pixel(200, 100, 0, 0);
      add_pixel(0, 200, 100, 0);
      add_pixel(254, 255, 0, 0);
      directed_count = pixels_to_send.size();

      // Random pixels: mostly free, with ties, grays, tiny and bright values
      for (int i = 0; i < RANDOM_PIXELS; i++) begin
         pick = $urandom_range(0, 99);
         r = $urandom_range(0, 255);
         g = $urandom_range(0, 255);
         b = $urandom_range(0, 255);
         v = $urandom_range(0, 255);
         if (pick < 60) begin
            // keep the free draw
         end else if (pick < 75) begin
            case ($urandom_range(0, 2))
               0: begin r = v; g = v; end
               1: begin g = v; b = v; end
               default: begin r = v; b = v; end
            endcase
         end else if (pick < 85) begin
            r = v; g = v; b = v;
         end else if (pick < 95) begin
            r = $urandom_range(0, 3);
            g = $urandom_range(0, 3);
            b = $urandom_range(0, 3);
         end else begin
            r = $urandom_range(250, 255);
            g = $urandom_range(250, 255);
            b = $urandom_range(250, 255);
         end
         add_pixel(r, g, b, (i % DRAIN_EVERY) == 0);
      end

      // Wait for the last transfer
      @(posedge clock);
      while (reset || pixels_to_send.size() != 0 || start)
         @(posedge clock);

      // Let outstanding results come back, with a limit
      waited = 0;
      while (results_seen != pixels_taken && waited < 200) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (results_seen != pixels_taken)
         report_mismatch("results never delivered", results_seen, pixels_taken);

      $display("Sent %0d pixels (%0d corner cases, rest random with ties and grays),",
               pixels_taken, directed_count);
      $display("checked %0d results, sender drained the pipeline %0d times.",
               results_seen, drain_count);
      if (error_count == 0) begin
         $display("rgb_to_hsv_pixel: match");
      end else begin
         $display("rgb_to_hsv_pixel: mismatch");
      end
      $finish;
   end

   // Timeout guard
   initial begin
      #2_000_000;
      $display("rgb_to_hsv_pixel: mismatch");
      $finish;
   end

endmodule
